FILE: src/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared constants, codes and types of the counting semaphore table.
// ----------------------------------------------------------------------------
package csem_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int WAIT_DEPTH = 8;
    localparam int PID_BITS   = 6;

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QPTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int QLEN_W  = $clog2(WAIT_DEPTH + 1);
    localparam int CNT_W   = 16;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 8;
    localparam int ST_W    = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int PID_IN_W   = 6;
    localparam int PID_OUT_W  = 6;

    localparam int WST_DEPTH = NUM_SLOTS << QPTR_W;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_UP      = 2'd2,
        OP_DOWN    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_QFULL   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_op                op;
        logic               bad;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   init;
        logic [PID_BITS-1:0] pid;
    } t_cmd;

endpackage

FILE: src/csem_ram.sv
// ----------------------------------------------------------------------------
// csem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/csem_front.sv
// ----------------------------------------------------------------------------
// csem_front
// Input handshake and classification of operations into commands.
// ----------------------------------------------------------------------------
module csem_front
    import csem_pkg::*;
(
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [IDX_W-1:0]     i_sem_index,
    input  logic [CNT_W-1:0]     i_initial_count,
    input  logic [PID_IN_W-1:0]  i_caller_process,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    t_op  op;
    logic in_range;

    always_comb begin
        op       = t_op'(i_opcode);
        in_range = {1'b0, i_sem_index} < (IDX_W + 1)'(NUM_SLOTS);

        o_cmd.op   = op;
        o_cmd.bad  = (op != OP_CREATE) && !in_range;
        o_cmd.slot = SLOT_W'(i_sem_index);
        o_cmd.init = i_initial_count;
        o_cmd.pid  = PID_BITS'(i_caller_process);
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

FILE: src/csem_cmd_q.sv
// ----------------------------------------------------------------------------
// csem_cmd_q
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module csem_cmd_q
    import csem_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_cmd  o_cmd
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp;
    logic [CMDQ_AW-1:0] r_rp;
    logic [CMDQ_CW-1:0] r_cnt;
    logic [CMDQ_AW-1:0] n_wp;
    logic [CMDQ_AW-1:0] n_rp;

    always_comb begin
        n_wp = (r_wp == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

endmodule

FILE: src/csem_back.sv
// ----------------------------------------------------------------------------
// csem_back
// Executes commands on the slot table and the waiter store, one at a time.
// ----------------------------------------------------------------------------
module csem_back
    import csem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_cmd                  i_cmd,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ST_W-1:0]       o_status,
    output logic [SLOT_OUT_W-1:0] o_slot_given,
    output logic                  o_wake_valid,
    output logic [PID_OUT_W-1:0]  o_wake_process,
    output logic                  o_last
);

    localparam int WST_AW = SLOT_W + QPTR_W;
    localparam int TSUM_W = QLEN_W + 1;

    // slot table
    logic [NUM_SLOTS-1:0] r_in_use;
    logic [CNT_W-1:0]     r_count [NUM_SLOTS];
    logic [QPTR_W-1:0]    r_head  [NUM_SLOTS];
    logic [QLEN_W-1:0]    r_len   [NUM_SLOTS];

    // current command
    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;
    logic [CNT_W-1:0]    r_cnt;
    logic [QPTR_W-1:0]   r_hd;
    logic [QLEN_W-1:0]   r_ln;
    logic                r_used;
    logic [SLOT_W-1:0]   r_free;
    logic                r_any_free;
    logic [QPTR_W-1:0]   r_pos;
    logic [QLEN_W-1:0]   r_k;

    // output register
    logic                  r_o_valid;
    t_status               r_o_status;
    logic [SLOT_OUT_W-1:0] r_o_slot;
    logic                  r_o_wv;
    logic [PID_OUT_W-1:0]  r_o_wp;
    logic                  r_o_last;

    logic                  out_free;
    logic                  pop;
    logic                  emit;
    t_status               e_status;
    logic [SLOT_W-1:0]     e_slot;
    logic                  e_wv;
    logic [PID_BITS-1:0]   e_wp;
    logic                  e_last;
    logic                  do_create;
    logic                  do_destroy;
    logic                  do_up;
    logic                  do_down;
    logic                  drain;
    logic                  up_wake;

    logic                  ram_we;
    logic [WST_AW-1:0]     ram_waddr;
    logic                  ram_re;
    logic [WST_AW-1:0]     ram_raddr;
    logic [PID_BITS-1:0]   ram_rdata;

    logic [SLOT_W-1:0]     c_free;
    logic                  c_any_free;
    logic [QPTR_W-1:0]     pos_next;
    logic [QPTR_W-1:0]     head_next;
    logic [QPTR_W-1:0]     tail_pos;
    logic [TSUM_W-1:0]     tsum;
    logic [CNT_W-1:0]      cnt_up;
    logic [CNT_W-1:0]      cnt_dn;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W:0] s;
        s = {1'b0, p} + 1'b1;
        return (s == (QPTR_W + 1)'(WAIT_DEPTH)) ? '0 : QPTR_W'(s);
    endfunction

    csem_ram #(
        .WIDTH (PID_BITS),
        .DEPTH (WST_DEPTH)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cmd.pid),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // lowest free slot
    always_comb begin
        c_free     = '0;
        c_any_free = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                c_free     = SLOT_W'(i);
                c_any_free = 1'b1;
            end
        end
    end

    always_comb begin
        pos_next  = ptr_inc(r_pos);
        head_next = ptr_inc(r_hd);
        tsum      = TSUM_W'(r_hd) + TSUM_W'(r_ln);
        tail_pos  = (tsum >= TSUM_W'(WAIT_DEPTH)) ? QPTR_W'(tsum - TSUM_W'(WAIT_DEPTH))
                                                  : QPTR_W'(tsum);
        cnt_up    = (r_cnt != CNT_MAX) ? r_cnt + CNT_W'(1) : r_cnt;
        cnt_dn    = (r_cnt != CNT_MIN) ? r_cnt - CNT_W'(1) : r_cnt;
        up_wake   = r_cnt[CNT_W-1] && (r_ln != '0);
    end

    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state    = r_state;
        pop        = 1'b0;
        emit       = 1'b0;
        e_status   = ST_DONE;
        e_slot     = '0;
        e_wv       = 1'b0;
        e_wp       = '0;
        e_last     = 1'b1;
        do_create  = 1'b0;
        do_destroy = 1'b0;
        do_up      = 1'b0;
        do_down    = 1'b0;
        drain      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = {r_cmd.slot, tail_pos};
        ram_re     = 1'b0;
        ram_raddr  = {i_cmd.slot, r_head[i_cmd.slot]};
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    pop     = 1'b1;
                    ram_re  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    priority if (r_cmd.op == OP_CREATE) begin
                        if (r_any_free) begin
                            do_create = 1'b1;
                            e_slot    = r_free;
                        end else begin
                            e_status = ST_IGNORED;
                        end
                    end else if (r_cmd.bad || !r_used) begin
                        e_status = ST_IGNORED;
                    end else begin
                        unique case (r_cmd.op)
                            OP_DESTROY: begin
                                do_destroy = 1'b1;
                                if (r_ln != '0) begin
                                    e_wv   = 1'b1;
                                    e_wp   = ram_rdata;
                                    e_last = (QLEN_W'(r_k + 1'b1) == r_ln);
                                    if (!e_last) begin
                                        drain     = 1'b1;
                                        ram_re    = 1'b1;
                                        ram_raddr = {r_cmd.slot, pos_next};
                                        n_state   = S_EXEC;
                                    end
                                end
                            end
                            OP_UP: begin
                                do_up = 1'b1;
                                if (up_wake) begin
                                    e_wv = 1'b1;
                                    e_wp = ram_rdata;
                                end
                            end
                            OP_DOWN: begin
                                do_down = 1'b1;
                                if (cnt_dn[CNT_W-1]) begin
                                    if (r_ln < QLEN_W'(WAIT_DEPTH)) begin
                                        ram_we   = 1'b1;
                                        e_status = ST_BLOCKED;
                                    end else begin
                                        e_status = ST_QFULL;
                                    end
                                end
                            end
                            default: begin
                                e_status = ST_IGNORED;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (do_create) begin
            r_in_use[r_free] <= 1'b1;
        end else if (do_destroy) begin
            r_in_use[r_cmd.slot] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd      <= i_cmd;
            r_cnt      <= r_count[i_cmd.slot];
            r_hd       <= r_head[i_cmd.slot];
            r_ln       <= r_len[i_cmd.slot];
            r_used     <= r_in_use[i_cmd.slot];
            r_pos      <= r_head[i_cmd.slot];
            r_k        <= '0;
            r_free     <= c_free;
            r_any_free <= c_any_free;
        end
        if (drain) begin
            r_pos <= pos_next;
            r_k   <= r_k + 1'b1;
        end
        if (do_create) begin
            r_count[r_free] <= r_cmd.init;
            r_head[r_free]  <= '0;
            r_len[r_free]   <= '0;
        end
        if (do_destroy) begin
            r_len[r_cmd.slot] <= '0;
        end
        if (do_up) begin
            r_count[r_cmd.slot] <= cnt_up;
            if (up_wake) begin
                r_head[r_cmd.slot] <= head_next;
                r_len[r_cmd.slot]  <= r_ln - 1'b1;
            end
        end
        if (do_down) begin
            r_count[r_cmd.slot] <= cnt_dn;
            if (ram_we) begin
                r_len[r_cmd.slot] <= r_ln + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_status <= e_status;
            r_o_slot   <= SLOT_OUT_W'(e_slot);
            r_o_wv     <= e_wv;
            r_o_wp     <= PID_OUT_W'(e_wp);
            r_o_last   <= e_last;
        end
    end

    assign o_pop          = pop;
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_slot_given   = r_o_slot;
    assign o_wake_valid   = r_o_wv;
    assign o_wake_process = r_o_wp;
    assign o_last         = r_o_last;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_state == S_IDLE)
        else $error("command popped while busy");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC && r_cmd.op != OP_CREATE && !r_cmd.bad && r_used
        |-> r_ln <= QLEN_W'(WAIT_DEPTH))
        else $error("wait queue length beyond depth");

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain |-> QLEN_W'(r_k + 1'b1) < r_ln)
        else $error("destroy drain past queue length");

    a_wake_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && e_wv |-> e_status == ST_DONE)
        else $error("wake with non-done status");

    a_write_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> do_down && r_state == S_EXEC)
        else $error("waiter store written outside down");

endmodule

FILE: src/counting_semaphore_table.sv
// An accepted item passes the command queue, the back's command register and
// the output register before its first result is valid. The back takes a new
// item only when done with the last; destroy gives one wake result per waiter
// (one result if none), one per cycle while the output is not stalled.
// Reset: synchronous active-low, frees every slot, empties the command queue.
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores with FIFO wait queues of process ids.
// ----------------------------------------------------------------------------
module counting_semaphore_table
    import csem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [IDX_W-1:0]      i_sem_index,
    input  logic [CNT_W-1:0]      i_initial_count,
    input  logic [PID_IN_W-1:0]   i_caller_process,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ST_W-1:0]       o_status,
    output logic [SLOT_OUT_W-1:0] o_slot_given,
    output logic                  o_wake_valid,
    output logic [PID_OUT_W-1:0]  o_wake_process,
    output logic                  o_last
);

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    csem_front u_front (
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_sem_index      (i_sem_index),
        .i_initial_count  (i_initial_count),
        .i_caller_process (i_caller_process),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    csem_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    csem_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_cmd          (q_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot_given   (o_slot_given),
        .o_wake_valid   (o_wake_valid),
        .o_wake_process (o_wake_process),
        .o_last         (o_last)
    );

endmodule
